### rtl/kuwahara_filter_unit_defines.svh
// assertion macros used by kuwahara_filter_unit
`ifndef KUWAHARA_FILTER_UNIT_DEFINES_SVH
`define KUWAHARA_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define KFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kff_pkg.sv
package kff_pkg;

  localparam int DEF_FRAME_SIDE = 128;
  localparam int DEF_MAX_WINDOW = 15;

  localparam int WIN_W   = 4;
  localparam int PIX_W   = 8;
  localparam int COORD_W = 7;

  localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // quadrant order: bottom-right, top-right, bottom-left, top-left
  localparam logic [3:0] QUAD_SEL_Y = 4'b0101;
  localparam logic [3:0] QUAD_SEL_X = 4'b0011;

  // tag that travels with each frame read
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic final_q;
  } rd_tag_t;

endpackage

### rtl/kff_ram.sv
module kff_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/kff_stats.sv
module kff_stats #(
  parameter int MaxWindow = kff_pkg::DEF_MAX_WINDOW,
  localparam int WMAX = (MaxWindow < 15) ? MaxWindow : 15,
  localparam int QMAX = ((WMAX + 1) / 2 < 1) ? 1 : (WMAX + 1) / 2,
  localparam int NMAX = QMAX * QMAX,
  localparam int NW   = $clog2(NMAX + 1),
  localparam int SW   = $clog2(NMAX * 255 + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kff_pkg::rd_tag_t        tag_i,
  input  logic [7:0]              pix_i,
  input  logic [NW-1:0]           n_i,
  output logic [SW-1:0]           best_sum_o,
  output logic                    done_o
);

  localparam int SSW  = $clog2(NMAX * 65025 + 1);
  localparam int P1W  = NW + SSW;
  localparam int P2W  = 2 * SW;
  localparam int VW   = (P1W > P2W) ? P1W : P2W;

  logic [SW-1:0]  acc_s_q, acc_s_d, s_now;
  logic [SSW-1:0] acc_ss_q, acc_ss_d, ss_now;
  logic [SW-1:0]  fin_s_q;
  logic [SSW-1:0] fin_ss_q;
  logic           fin_vld_q, fin_first_q, fin_final_q;
  logic [P1W-1:0] p1_q;
  logic [P2W-1:0] p2_q;
  logic [SW-1:0]  sb_q;
  logic           b_vld_q, b_first_q, b_final_q;
  logic [VW-1:0]  var_c, best_var_q;
  logic [SW-1:0]  best_s_q;
  logic           done_q;

  // accumulate
  always_comb begin
    s_now    = acc_s_q + SW'(pix_i);
    ss_now   = acc_ss_q + SSW'(pix_i) * SSW'(pix_i);
    acc_s_d  = acc_s_q;
    acc_ss_d = acc_ss_q;
    if (tag_i.vld) begin
      acc_s_d  = tag_i.last ? '0 : s_now;
      acc_ss_d = tag_i.last ? '0 : ss_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_s_q     <= '0;
      acc_ss_q    <= '0;
      fin_vld_q   <= 1'b0;
      fin_first_q <= 1'b0;
      fin_final_q <= 1'b0;
      b_vld_q     <= 1'b0;
      b_first_q   <= 1'b0;
      b_final_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      acc_s_q     <= acc_s_d;
      acc_ss_q    <= acc_ss_d;
      fin_vld_q   <= tag_i.vld & tag_i.last;
      fin_first_q <= tag_i.first;
      fin_final_q <= tag_i.final_q;
      b_vld_q     <= fin_vld_q;
      b_first_q   <= fin_first_q;
      b_final_q   <= fin_final_q;
      done_q      <= b_vld_q & b_final_q;
    end
  end

  // payload stages
  assign var_c = VW'(p1_q) - VW'(p2_q);

  always_ff @(posedge clk_i) begin
    if (tag_i.vld && tag_i.last) begin
      fin_s_q  <= s_now;
      fin_ss_q <= ss_now;
    end
    p1_q <= P1W'(n_i) * P1W'(fin_ss_q);
    p2_q <= P2W'(fin_s_q) * P2W'(fin_s_q);
    sb_q <= fin_s_q;
    // the earliest quadrant wins ties
    if (b_vld_q && (b_first_q || var_c < best_var_q)) begin
      best_var_q <= var_c;
      best_s_q   <= sb_q;
    end
  end

  assign best_sum_o = best_s_q;
  assign done_o     = done_q;

endmodule

### rtl/kff_div.sv
module kff_div #(
  parameter int MaxWindow = kff_pkg::DEF_MAX_WINDOW,
  localparam int WMAX = (MaxWindow < 15) ? MaxWindow : 15,
  localparam int QMAX = ((WMAX + 1) / 2 < 1) ? 1 : (WMAX + 1) / 2,
  localparam int NMAX = QMAX * QMAX,
  localparam int NW   = $clog2(NMAX + 1),
  localparam int SW   = $clog2(NMAX * 255 + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic [SW-1:0] quotient_o,
  output logic          done_o
);

  localparam int CNTW = $clog2(SW + 1);

  logic [SW-1:0]   dvd_q;
  logic [NW-1:0]   rem_q;
  logic [NW-1:0]   dsr_q;
  logic [CNTW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [NW:0]     rem_sh, rem_sub;
  logic            qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, dvd_q[SW-1]};
    qbit    = rem_sh >= {1'b0, dsr_q};
    rem_sub = qbit ? rem_sh - {1'b0, dsr_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && run_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNTW'(SW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      dvd_q <= {dvd_q[SW-2:0], qbit};
      rem_q <= rem_sub[NW-1:0];
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

### rtl/kuwahara_filter_unit.sv
// channel   | direction | signals                                   | handshake
// ----------+-----------+-------------------------------------------+---------------------
// command   | in        | mode_i row_i col_i pixel_i                | start & !busy
// result    | out       | filtered_o                                | valid_o, one cycle
// config    | in        | cfg_data_i (window width)                 | cfg_valid_i & ready
//
// a pixel write is taken in the accept cycle and never raises busy
// a filter request holds busy through a scan of 4*q*q frame reads (one per cycle),
//   then through the drain, the divider and the result state, with q taken as one
//   when the window gives one or less
// reset loads a window width of 5; the frame store holds nothing defined until written
// the receiver cannot stall: filtered_o is qualified by valid_o and holds until the next result
`include "kuwahara_filter_unit_defines.svh"

module kuwahara_filter_unit #(
  parameter int FRAME_SIDE = kff_pkg::DEF_FRAME_SIDE,
  parameter int MAX_WINDOW = kff_pkg::DEF_MAX_WINDOW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [kff_pkg::COORD_W-1:0] row_i,
  input  logic [kff_pkg::COORD_W-1:0] col_i,
  input  logic [kff_pkg::PIX_W-1:0]   pixel_i,
  output logic                        valid_o,
  output logic [kff_pkg::PIX_W-1:0]   filtered_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kff_pkg::WIN_W-1:0]   cfg_data_i
);

  localparam int CW   = $clog2(FRAME_SIDE);
  localparam int AW   = $clog2(FRAME_SIDE * FRAME_SIDE);
  localparam int SCW  = $clog2(2 * FRAME_SIDE + MAX_WINDOW) + 2;
  localparam int WMAX = (MAX_WINDOW < 15) ? MAX_WINDOW : 15;
  localparam int QMAX = ((WMAX + 1) / 2 < 1) ? 1 : (WMAX + 1) / 2;
  localparam int QW   = $clog2(QMAX + 1);
  localparam int NMAX = QMAX * QMAX;
  localparam int NW   = $clog2(NMAX + 1);
  localparam int SW   = $clog2(NMAX * 255 + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [kff_pkg::WIN_W-1:0] win_q;
  logic [kff_pkg::WIN_W-1:0] win_sat;
  logic [kff_pkg::WIN_W:0]   q_full;
  logic [QW-1:0]             q_new, rad_new;

  logic [CW-1:0]  py_q, px_q;
  logic [QW-1:0]  q_q, rad_q;
  logic [NW-1:0]  n_q;
  logic [QW-1:0]  oy_q, ox_q;
  logic [1:0]     k_q;
  logic [QW-1:0]  shift;
  logic           last_px;

  logic signed [SCW-1:0] cy, cx;
  logic [CW-1:0]         fy, fx;

  logic                   accept, ram_we;
  logic [AW-1:0]          waddr, raddr;
  logic [7:0]             rdata;
  kff_pkg::rd_tag_t       tag_q;
  logic [SW-1:0]          best_sum;
  logic                   stats_done, div_start, div_done;
  logic [SW-1:0]          quot;
  logic [kff_pkg::PIX_W-1:0] res_q;

  // reflect-101 then clamp into the frame
  function automatic logic [CW-1:0] fold(input logic signed [SCW-1:0] r);
    logic signed [SCW-1:0] t;
    t = r;
    if (t < 0) t = -t;
    if (t >= FRAME_SIDE) t = SCW'(2 * FRAME_SIDE - 2) - t;
    if (t < 0) t = '0;
    if (t >= FRAME_SIDE) t = SCW'(FRAME_SIDE - 1);
    return t[CW-1:0];
  endfunction

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // window geometry; q of one or less degenerates to reads of the centre pixel alone
  always_comb begin
    win_sat = (int'(win_q) > MAX_WINDOW) ? kff_pkg::WIN_W'(MAX_WINDOW) : win_q;
    q_full  = ({1'b0, win_sat} + 1'b1) >> 1;
    if (q_full <= 1) begin
      q_new   = QW'(1);
      rad_new = '0;
    end else begin
      q_new   = QW'(q_full);
      rad_new = QW'(win_sat >> 1);
    end
  end

  // frame writes go straight to the ram in the accept cycle
  assign ram_we = accept && (mode_i == kff_pkg::MODE_WRITE)
                  && (int'(row_i) < FRAME_SIDE) && (int'(col_i) < FRAME_SIDE);
  assign waddr  = AW'(int'(row_i) * FRAME_SIDE + int'(col_i));

  // read coordinate for the current quadrant pixel
  assign shift   = q_q - 1'b1;
  assign last_px = (ox_q == shift) && (oy_q == shift);

  always_comb begin
    cy = SCW'(py_q) - SCW'(rad_q) + SCW'(oy_q)
         + (kff_pkg::QUAD_SEL_Y[k_q] ? SCW'(shift) : '0);
    cx = SCW'(px_q) - SCW'(rad_q) + SCW'(ox_q)
         + (kff_pkg::QUAD_SEL_X[k_q] ? SCW'(shift) : '0);
    fy = fold(cy);
    fx = fold(cx);
  end

  assign raddr = AW'(int'(fy) * FRAME_SIDE + int'(fx));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == kff_pkg::MODE_READ) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_px && k_q == 2'd3) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stats_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign div_start = (state_q == ST_DRAIN) && stats_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= kff_pkg::WIN_RESET;
      tag_q   <= '0;
      oy_q    <= '0;
      ox_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) win_q <= cfg_data_i;
      if (state_q == ST_IDLE) begin
        tag_q <= '0;
        oy_q  <= '0;
        ox_q  <= '0;
        k_q   <= '0;
      end else if (state_q == ST_SCAN) begin
        tag_q <= '{vld: 1'b1, first: (k_q == 2'd0), last: last_px,
                   final_q: last_px && (k_q == 2'd3)};
        if (ox_q == shift) begin
          ox_q <= '0;
          if (oy_q == shift) begin
            oy_q <= '0;
            k_q  <= k_q + 1'b1;
          end else begin
            oy_q <= oy_q + 1'b1;
          end
        end else begin
          ox_q <= ox_q + 1'b1;
        end
      end else begin
        tag_q <= '0;
      end
    end
  end

  // request payload; out-of-frame addresses clamp to the last row or column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      py_q  <= (int'(row_i) >= FRAME_SIDE) ? CW'(FRAME_SIDE - 1) : CW'(row_i);
      px_q  <= (int'(col_i) >= FRAME_SIDE) ? CW'(FRAME_SIDE - 1) : CW'(col_i);
      q_q   <= q_new;
      rad_q <= rad_new;
      n_q   <= NW'(q_new) * NW'(q_new);
    end
    if (div_done) res_q <= quot[kff_pkg::PIX_W-1:0];
  end

  kff_ram #(
    .Width(kff_pkg::PIX_W),
    .Depth(FRAME_SIDE * FRAME_SIDE)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(pixel_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  kff_stats #(
    .MaxWindow(MAX_WINDOW)
  ) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag_q),
    .pix_i     (rdata),
    .n_i       (n_q),
    .best_sum_o(best_sum),
    .done_o    (stats_done)
  );

  kff_div #(
    .MaxWindow(MAX_WINDOW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(best_sum),
    .divisor_i (n_q),
    .quotient_o(quot),
    .done_o    (div_done)
  );

  assign valid_o    = (state_q == ST_OUT);
  assign filtered_o = res_q;

  `KFU_ASSERT_NXT(a_strobe_single, valid_o, !valid_o, "result strobe longer than one cycle")
  `KFU_ASSERT_NOW(a_no_write_busy, ram_we, state_q == ST_IDLE, "frame write during request")
  `KFU_ASSERT_NOW(a_stats_drain, stats_done, state_q == ST_DRAIN, "quadrant stats out of step")
  `KFU_ASSERT_NOW(a_div_state, div_done, state_q == ST_DIV, "divider finished outside div")

endmodule

### sim/kuwahara_checker.sv
module kuwahara_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        mode_i,
  input  logic [kff_pkg::COORD_W-1:0] row_i,
  input  logic [kff_pkg::COORD_W-1:0] col_i,
  input  logic [kff_pkg::PIX_W-1:0]   pixel_i,
  input  logic                        valid_o,
  input  logic [kff_pkg::PIX_W-1:0]   filtered_o,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [kff_pkg::WIN_W-1:0]   cfg_data_i,
  output int                          fail_count,
  output int                          pending
);
  localparam int SIDE = kff_pkg::DEF_FRAME_SIDE;

  logic [kff_pkg::PIX_W-1:0] frame_copy [SIDE*SIDE];
  logic [kff_pkg::WIN_W-1:0] win_size;
  logic [kff_pkg::PIX_W-1:0] filtered_due [$];

  initial begin
    foreach (frame_copy[i]) frame_copy[i] = '0;
  end

  // reflect-101 then clamp
  function automatic int fold_edge(int r);
    if (r < 0) r = -r;
    if (r >= SIDE) r = 2 * SIDE - r - 2;
    if (r < 0) r = 0;
    if (r >= SIDE) r = SIDE - 1;
    return r;
  endfunction

  function automatic logic [kff_pkg::PIX_W-1:0] kuwahara_mean(int py, int px);
    int w, q, rad;
    longint unsigned n, s, ss, spread, best_spread, chosen_mean, v;
    int by, bx;
    w = win_size;
    if (w > kff_pkg::DEF_MAX_WINDOW) w = kff_pkg::DEF_MAX_WINDOW;
    q = (w + 1) / 2;
    if (q <= 1) return frame_copy[py*SIDE + px];
    rad = w / 2;
    n = q * q;
    best_spread = 0;
    chosen_mean = 0;
    for (int k = 0; k < 4; k++) begin
      by = py - rad + (kff_pkg::QUAD_SEL_Y[k] ? q - 1 : 0);
      bx = px - rad + (kff_pkg::QUAD_SEL_X[k] ? q - 1 : 0);
      s = 0;
      ss = 0;
      for (int oy = 0; oy < q; oy++)
        for (int ox = 0; ox < q; ox++) begin
          v = frame_copy[fold_edge(by + oy)*SIDE + fold_edge(bx + ox)];
          s += v;
          ss += v * v;
        end
      spread = n * ss - s * s;
      // earliest quadrant keeps a tie
      if (k == 0 || spread < best_spread) begin
        best_spread = spread;
        chosen_mean = s / n;
      end
    end
    return chosen_mean[kff_pkg::PIX_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size <= kff_pkg::WIN_RESET;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) win_size <= cfg_data_i;
      if (start && !busy) begin
        if (mode_i == kff_pkg::MODE_WRITE) frame_copy[row_i*SIDE + col_i] = pixel_i;
        else filtered_due.push_back(kuwahara_mean(row_i, col_i));
      end
      if (valid_o) begin
        if (filtered_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %0d", filtered_o);
          fail_count <= fail_count + 1;
        end else begin
          if (filtered_o !== filtered_due[0]) begin
            if (fail_count < 10)
              $display("filtered mismatch: expected %0d got %0d", filtered_due[0], filtered_o);
            fail_count <= fail_count + 1;
          end
          void'(filtered_due.pop_front());
        end
      end
      pending <= filtered_due.size();
    end
  end
endmodule

### sim/testbench.sv
module testbench;
  localparam int SIDE = kff_pkg::DEF_FRAME_SIDE;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic mode_i = kff_pkg::MODE_WRITE;
  logic [kff_pkg::COORD_W-1:0] row_i = '0;
  logic [kff_pkg::COORD_W-1:0] col_i = '0;
  logic [kff_pkg::PIX_W-1:0] pixel_i = '0;
  logic valid_o;
  logic [kff_pkg::PIX_W-1:0] filtered_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [kff_pkg::WIN_W-1:0] cfg_data_i = '0;
  int fail_count, pending;

  // which frame entries hold a defined pixel
  bit loaded [SIDE][SIDE];
  int win_now = 5;
  int idle_pct = 0;

  always #1 clk_i = ~clk_i;

  kuwahara_filter_unit dut (.*);
  kuwahara_checker chk (.*);

  function automatic int fold_edge(int r);
    if (r < 0) r = -r;
    if (r >= SIDE) r = 2 * SIDE - r - 2;
    if (r < 0) r = 0;
    if (r >= SIDE) r = SIDE - 1;
    return r;
  endfunction

  // true when every pixel the request touches has been loaded
  function automatic bit footprint_loaded(int py, int px);
    int q, rad;
    q = (win_now + 1) / 2;
    if (q <= 1) return loaded[py][px];
    rad = win_now / 2;
    for (int dy = 0; dy <= 2*q - 2; dy++)
      for (int dx = 0; dx <= 2*q - 2; dx++)
        if (!loaded[fold_edge(py - rad + dy)][fold_edge(px - rad + dx)]) return 0;
    return 1;
  endfunction

  // one item over the command channel, start stays up between back-to-back items
  task automatic send_item(logic m, int r, int c, int p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= m;
    row_i <= kff_pkg::COORD_W'(r);
    col_i <= kff_pkg::COORD_W'(c);
    pixel_i <= kff_pkg::PIX_W'(p);
    do @(posedge clk_i); while (busy);
    if (m == kff_pkg::MODE_WRITE) loaded[r][c] = 1;
  endtask

  // corner blocks cover every reflected window reach near the edges
  function automatic int corner_coord();
    return $urandom_range(1) ? $urandom_range(4) : SIDE - 1 - $urandom_range(4);
  endfunction

  task automatic request_somewhere();
    int r, c;
    r = $urandom_range(SIDE - 1);
    c = $urandom_range(SIDE - 1);
    if (!footprint_loaded(r, c)) begin
      r = corner_coord();
      c = corner_coord();
    end
    send_item(kff_pkg::MODE_READ, r, c, $urandom_range(255));
  endtask

  // window changes only with nothing in flight
  task automatic set_window(int w);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= kff_pkg::WIN_W'(w);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_now = w;
  endtask

  initial begin
    int phase_win [8] = '{15, 1, 2, 5, 8, 3, 14, 15};
    int r, c;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_window(15);

    // load the four 12x12 corner blocks
    foreach (phase_win[i]) ;
    for (int y = 0; y < 24; y++)
      for (int x = 0; x < 24; x++)
        send_item(kff_pkg::MODE_WRITE, y < 12 ? y : SIDE - 24 + y,
                  x < 12 ? x : SIDE - 24 + x, $urandom_range(255));

    // extremes of pixel value and position
    send_item(kff_pkg::MODE_WRITE, 0, 0, 0);
    send_item(kff_pkg::MODE_WRITE, SIDE - 1, SIDE - 1, 255);
    send_item(kff_pkg::MODE_WRITE, 0, SIDE - 1, 255);
    send_item(kff_pkg::MODE_WRITE, SIDE - 1, 0, 0);
    send_item(kff_pkg::MODE_READ, 0, 0, 255);
    send_item(kff_pkg::MODE_READ, SIDE - 1, SIDE - 1, 0);
    send_item(kff_pkg::MODE_READ, 0, SIDE - 1, 0);
    send_item(kff_pkg::MODE_READ, SIDE - 1, 0, 255);
    send_item(kff_pkg::MODE_READ, 4, 4, 0);
    send_item(kff_pkg::MODE_READ, SIDE - 5, 3, 0);
    // flat 3x3 patch read with a 3-wide window makes all quadrants tie
    for (int y = 0; y < 12; y++)
      for (int x = SIDE - 12; x < SIDE; x++)
        if (y < 3 && x >= SIDE - 3) send_item(kff_pkg::MODE_WRITE, y, x, 77);
    set_window(3);
    send_item(kff_pkg::MODE_READ, 1, SIDE - 2, 0);

    foreach (phase_win[p]) begin
      set_window(phase_win[p]);
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 85 : 7;
      // small windows pass pixels straight through, so also probe narrow edges
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(99) < 80) begin
            r = corner_coord() + ($urandom_range(1) ? 0 : 0);
            c = corner_coord();
            r = r < 12 ? $urandom_range(11) : SIDE - 1 - $urandom_range(11);
            c = c < 12 ? $urandom_range(11) : SIDE - 1 - $urandom_range(11);
          end else begin
            r = $urandom_range(SIDE - 1);
            c = $urandom_range(SIDE - 1);
          end
          send_item(kff_pkg::MODE_WRITE, r, c, $urandom_range(255));
        end else begin
          request_somewhere();
        end
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("kuwahara_filter_unit regression: pass");
    else $display("kuwahara_filter_unit regression: fail");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("kuwahara_filter_unit regression: fail");
    $finish;
  end
endmodule
